@@ rtl/core/ipud_pkg.sv @@
`default_nettype none
package ipud_pkg;

    localparam int unsigned BLOCK_BYTES = 640;
    localparam int unsigned BLK_W       = 10;
    localparam int unsigned HDR_W       = 8;
    localparam int unsigned LEN_W       = 16;

    localparam logic [HDR_W-1:0] HEADER_SKIP   = 8'd12;
    localparam logic [BLK_W-1:0] BLOCK_LAST_POS = BLK_W'(BLOCK_BYTES - 1);

    localparam logic [7:0] MARKER_BYTE  = 8'h24;
    localparam logic [7:0] CHANNEL_BYTE = 8'h00;

    localparam logic [14:0] ULAW_BIAS = 15'd132;
    localparam logic [15:0] ULAW_CLIP = 16'd32635;

    typedef struct packed {
        logic signed [15:0] pcm;
        logic [BLK_W-1:0]   pos;
        logic               last;
    } t_sample;

endpackage
`default_nettype wire

@@ rtl/core/ipud_ifs.sv @@
`default_nettype none
interface ipud_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface ipud_out_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                ulaw_byte;
    logic [ipud_pkg::BLK_W-1:0] block_position;
    logic                      block_last;

    modport source (output valid, output ulaw_byte, output block_position,
                    output block_last, input ready);
    modport sink (input valid, input ulaw_byte, input block_position,
                  input block_last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ipud_parser.sv @@
`default_nettype none
module ipud_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_action,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_ready,
    output logic                   o_smp_valid,
    output ipud_pkg::t_sample      o_smp,
    input  wire logic              i_smp_take
);
    import ipud_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_CHAN = 3'd1;
    localparam logic [2:0] PH_LENH = 3'd2;
    localparam logic [2:0] PH_LENL = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;

    logic [2:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic [HDR_W-1:0] r_skip, n_skip;
    logic [7:0]       r_low, n_low;
    logic             r_have, n_have;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic             r_smp_vld, n_smp_vld;
    t_sample          r_smp, n_smp;

    logic             accept;
    logic             emit;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] rem_dec;
    logic [HDR_W-1:0] skip_dec;
    logic             blk_last;

    assign o_ready     = !r_smp_vld || i_smp_take;
    assign accept      = i_valid && o_ready;
    assign o_smp_valid = r_smp_vld;
    assign o_smp       = r_smp;

    assign len      = {r_rem[15:8], i_rx_byte};
    assign rem_dec  = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
    assign skip_dec = (r_skip != '0) ? r_skip - 1'b1 : r_skip;
    assign blk_last = (r_blk >= BLOCK_LAST_POS);

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_skip  = r_skip;
        n_low   = r_low;
        n_have  = r_have;
        emit    = 1'b0;
        if (i_action) begin
            n_phase = PH_HUNT;
            n_rem   = '0;
            n_skip  = '0;
            n_low   = '0;
            n_have  = 1'b0;
        end else begin
            case (r_phase)
                PH_CHAN: begin
                    n_phase = (i_rx_byte == CHANNEL_BYTE) ? PH_LENH : PH_HUNT;
                end
                PH_LENH: begin
                    n_rem   = {i_rx_byte, 8'h00};
                    n_phase = PH_LENL;
                end
                PH_LENL: begin
                    n_rem  = (len >= LEN_W'(HEADER_SKIP)) ? len - LEN_W'(HEADER_SKIP) : '0;
                    n_skip = HEADER_SKIP;
                    if (HEADER_SKIP != '0) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = (n_rem != '0) ? PH_DATA : PH_HUNT;
                        n_have  = 1'b0;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = (r_rem != '0) ? PH_DATA : PH_HUNT;
                        n_have  = 1'b0;
                    end
                end
                PH_DATA: begin
                    if (!r_have) begin
                        n_low  = i_rx_byte;
                        n_have = 1'b1;
                    end else begin
                        emit   = 1'b1;
                        n_have = 1'b0;
                    end
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_HUNT;
                        n_have  = 1'b0;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == MARKER_BYTE) ? PH_CHAN : PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        n_blk     = r_blk;
        n_smp     = r_smp;
        n_smp_vld = r_smp_vld && !i_smp_take;
        if (accept && emit) begin
            n_smp.pcm  = {i_rx_byte, r_low};
            n_smp.pos  = r_blk;
            n_smp.last = blk_last;
            n_smp_vld  = 1'b1;
            n_blk      = blk_last ? '0 : r_blk + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_rem     <= '0;
            r_skip    <= '0;
            r_low     <= '0;
            r_have    <= 1'b0;
            r_blk     <= '0;
            r_smp_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_rem   <= n_rem;
                r_skip  <= n_skip;
                r_low   <= n_low;
                r_have  <= n_have;
            end
            r_blk     <= n_blk;
            r_smp_vld <= n_smp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp <= n_smp;
    end

endmodule
`default_nettype wire

@@ rtl/core/ipud_encoder.sv @@
`default_nettype none
module ipud_encoder (
    input  wire logic signed [15:0] i_pcm,
    output logic [7:0]              o_code
);
    import ipud_pkg::*;

    logic [15:0] mag;
    logic [15:0] mag_clip;
    logic [14:0] v;
    logic [2:0]  seg;
    logic [14:0] shifted;
    logic [7:0]  code;
    logic [7:0]  mask;

    always_comb begin
        if (i_pcm[15]) begin
            mag  = 16'(-i_pcm);
            mask = 8'h7F;
        end else begin
            mag  = i_pcm;
            mask = 8'hFF;
        end
        mag_clip = (mag > ULAW_CLIP) ? ULAW_CLIP : mag;
        v        = mag_clip[14:0] + ULAW_BIAS;
        seg      = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (v[7+k]) begin
                seg = 3'(k);
            end
        end
        shifted = v >> (4'(seg) + 4'd3);
        code    = {1'b0, seg, shifted[3:0]};
        o_code  = code ^ mask;
    end

endmodule
`default_nettype wire

@@ rtl/core/interleaved_pcm_to_ulaw_deframer_core.sv @@
// A completed sample is registered in the parser, then encoded into the output register.
// Throughput: one byte per cycle, sustained while the result side takes one per cycle.
// The parse and block-count registers set the pace; the encoder sits between two registers.
// Reset (synchronous, active low) returns the parser to hunting and clears the block count.
// A restart transaction clears the parser but keeps the block count.
`default_nettype none
module interleaved_pcm_to_ulaw_deframer_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ipud_in_if.sink    i_item,
    ipud_out_if.source o_result
);
    import ipud_pkg::*;

    logic    smp_valid;
    logic    smp_take;
    t_sample smp;
    logic [7:0] code;

    logic             r_out_vld;
    logic [7:0]       r_ulaw;
    logic [BLK_W-1:0] r_pos;
    logic             r_last;

    assign smp_take = smp_valid && (!r_out_vld || o_result.ready);

    ipud_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_item.valid),
        .i_action    (i_item.action),
        .i_rx_byte   (i_item.rx_byte),
        .o_ready     (i_item.ready),
        .o_smp_valid (smp_valid),
        .o_smp       (smp),
        .i_smp_take  (smp_take)
    );

    ipud_encoder u_encoder (
        .i_pcm  (smp.pcm),
        .o_code (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (smp_take) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_take) begin
            r_ulaw <= code;
            r_pos  <= smp.pos;
            r_last <= smp.last;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.ulaw_byte      = r_ulaw;
    assign o_result.block_position = r_pos;
    assign o_result.block_last     = r_last;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ipud_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_CHAN   = 3'd1,
        ST_LEN_HI = 3'd2,
        ST_LEN_LO = 3'd3,
        ST_SKIP   = 3'd4,
        ST_DATA   = 3'd5
    } t_frame_phase;

    typedef struct packed {
        logic [7:0]       ulaw;
        logic [BLK_W-1:0] pos;
        logic             last;
    } t_ulaw_rec;

    typedef struct {
        logic       act;
        logic [7:0] b;
        int         reps;
        logic       chk;
        logic [7:0] ulaw;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    ipud_in_if  in_ch ();
    ipud_out_if out_ch ();

    interleaved_pcm_to_ulaw_deframer_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    t_frame_phase     fr_phase     = ST_HUNT;
    logic [LEN_W-1:0] fr_payload   = '0;
    logic [HDR_W-1:0] fr_skip      = '0;
    logic [7:0]       fr_low_byte  = '0;
    logic             fr_low_valid = 1'b0;
    logic [BLK_W-1:0] fr_blk_pos   = '0;

    t_ulaw_rec expected_ulaw[$];
    t_ulaw_rec want;
    int        errors       = 0;
    int        items_sent   = 0;
    int        quiet_cycles = 0;
    int        send_run     = 0;
    bit        send_choppy  = 1'b0;
    int        recv_run     = 0;
    bit        recv_choppy  = 1'b0;
    logic      hold_req     = 1'b0;
    logic      calm         = 1'b0;

    t_step plan [23] = '{
        '{1'b0, 8'h24,  1, 1'b0, 8'h00},
        '{1'b0, 8'h01,  1, 1'b0, 8'h00},
        '{1'b0, 8'h24,  1, 1'b0, 8'h00},
        '{1'b0, 8'h00,  1, 1'b0, 8'h00},
        '{1'b0, 8'h00,  1, 1'b0, 8'h00},
        '{1'b0, 8'h05,  1, 1'b0, 8'h00},
        '{1'b0, 8'h24, 12, 1'b0, 8'h00},
        '{1'b0, 8'h24,  1, 1'b0, 8'h00},
        '{1'b0, 8'h00,  1, 1'b0, 8'h00},
        '{1'b0, 8'h00,  1, 1'b0, 8'h00},
        '{1'b0, 8'h15,  1, 1'b0, 8'h00},
        '{1'b0, 8'hA5, 12, 1'b0, 8'h00},
        '{1'b0, 8'hFF,  1, 1'b0, 8'h00},
        '{1'b0, 8'h7F,  1, 1'b1, 8'h80},
        '{1'b0, 8'h00,  1, 1'b0, 8'h00},
        '{1'b0, 8'h80,  1, 1'b1, 8'h00},
        '{1'b0, 8'h00,  1, 1'b0, 8'h00},
        '{1'b0, 8'h00,  1, 1'b1, 8'hFF},
        '{1'b0, 8'hFF,  1, 1'b0, 8'h00},
        '{1'b0, 8'hFF,  1, 1'b1, 8'h7F},
        '{1'b0, 8'h55,  1, 1'b0, 8'h00},
        '{1'b0, 8'h24,  1, 1'b0, 8'h00},
        '{1'b1, 8'h24,  1, 1'b0, 8'h00}
    };

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] ulaw_of_pcm(input logic signed [15:0] pcm);
        logic [15:0] mag;
        logic [15:0] biased;
        logic [2:0]  seg;
        logic [7:0]  code;
        mag = pcm[15] ? 16'(-pcm) : pcm;
        if (mag > ULAW_CLIP) begin
            mag = ULAW_CLIP;
        end
        biased = mag + 16'(ULAW_BIAS);
        seg = 3'd7;
        for (int s = 6; s >= 0; s--) begin
            if (biased < (16'h0100 << s)) begin
                seg = 3'(s);
            end
        end
        code = {1'b0, seg, 4'(biased >> (seg + 3))};
        return pcm[15] ? (code ^ 8'h7F) : (code ^ 8'hFF);
    endfunction

    function automatic void close_header();
        fr_phase = (fr_payload != '0) ? ST_DATA : ST_HUNT;
        fr_low_valid = 1'b0;
    endfunction

    // Advances the frame parser by one transaction; returns 1 when a sample completes.
    function automatic bit parse_rx(input logic act, input logic [7:0] b,
                                    output t_ulaw_rec rec);
        logic [15:0] len;
        bit          hit;
        hit = 1'b0;
        rec = '0;
        if (act) begin
            fr_phase = ST_HUNT;
            fr_payload = '0;
            fr_skip = '0;
            fr_low_byte = '0;
            fr_low_valid = 1'b0;
            return 1'b0;
        end
        case (fr_phase)
            ST_CHAN: begin
                fr_phase = (b == CHANNEL_BYTE) ? ST_LEN_HI : ST_HUNT;
            end
            ST_LEN_HI: begin
                fr_payload = {b, 8'h00};
                fr_phase = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                len = {fr_payload[15:8], b};
                fr_payload = (len >= 16'(HEADER_SKIP)) ? len - 16'(HEADER_SKIP) : 16'd0;
                fr_skip = HEADER_SKIP;
                if (fr_skip != '0) begin
                    fr_phase = ST_SKIP;
                end else begin
                    close_header();
                end
            end
            ST_SKIP: begin
                if (fr_skip != '0) begin
                    fr_skip--;
                end
                if (fr_skip == '0) begin
                    close_header();
                end
            end
            ST_DATA: begin
                if (!fr_low_valid) begin
                    fr_low_byte = b;
                    fr_low_valid = 1'b1;
                end else begin
                    rec.ulaw = ulaw_of_pcm({b, fr_low_byte});
                    rec.pos = fr_blk_pos;
                    rec.last = (fr_blk_pos >= BLOCK_LAST_POS);
                    fr_blk_pos = rec.last ? '0 : fr_blk_pos + 1'b1;
                    fr_low_valid = 1'b0;
                    hit = 1'b1;
                end
                if (fr_payload != '0) begin
                    fr_payload--;
                end
                if (fr_payload == '0) begin
                    fr_phase = ST_HUNT;
                    fr_low_valid = 1'b0;
                end
            end
            default: begin
                fr_phase = (b == MARKER_BYTE) ? ST_CHAN : ST_HUNT;
            end
        endcase
        return hit;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_byte(input logic act, input logic [7:0] b,
                             input logic chk = 1'b0, input logic [7:0] typed = 8'h00);
        t_ulaw_rec rec;
        int        gap;
        if (send_run == 0) begin
            send_run = $urandom_range(10, 60);
            send_choppy = $urandom_range(0, 1);
        end
        send_run--;
        if (send_choppy && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.rx_byte <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (parse_rx(act, b, rec)) begin
            if (chk) begin
                rec.ulaw = typed;
            end
            expected_ulaw.push_back(rec);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (expected_ulaw.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int force_len, input bit hold);
        logic [7:0]  bytes_q[$];
        int          kind;
        int          plen;
        int          cut;
        logic [15:0] flen;
        logic [15:0] smp;
        repeat ($urandom_range(0, 3)) push_byte(1'b0, 8'($urandom));
        kind = (force_len >= 0) ? 99 : $urandom_range(0, 19);
        if (force_len >= 0) begin
            plen = force_len;
        end else if ($urandom_range(0, 7) == 0) begin
            plen = $urandom_range(100, 300);
        end else begin
            plen = $urandom_range(0, 64);
        end
        flen = (kind == 1) ? 16'($urandom_range(0, 11)) : 16'(plen) + 16'(HEADER_SKIP);
        bytes_q.push_back(MARKER_BYTE);
        bytes_q.push_back((kind == 0) ? 8'($urandom_range(1, 255)) : CHANNEL_BYTE);
        bytes_q.push_back(flen[15:8]);
        bytes_q.push_back(flen[7:0]);
        repeat (HEADER_SKIP) bytes_q.push_back(8'($urandom));
        for (int i = 0; i < plen; i += 2) begin
            case ($urandom_range(0, 11))
                0: smp = 16'h7FFF;
                1: smp = 16'h8000;
                2: smp = 16'h0000;
                3: smp = 16'hFFFF;
                4: smp = 16'(32630 + $urandom_range(0, 10));
                5: smp = -16'(32630 + $urandom_range(0, 10));
                default: smp = 16'($urandom);
            endcase
            bytes_q.push_back(smp[7:0]);
            if (i + 1 < plen) begin
                bytes_q.push_back(smp[15:8]);
            end
        end
        cut = (kind == 2) ? $urandom_range(0, bytes_q.size() - 1) : -1;
        foreach (bytes_q[i]) begin
            if (i == cut) begin
                push_byte(1'b1, 8'($urandom));
                break;
            end
            if (hold && i == 4 + int'(HEADER_SKIP)) begin
                hold_req <= 1'b1;
            end
            push_byte(1'b0, bytes_q[i]);
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_run == 0) begin
                recv_run = $urandom_range(10, 60);
                recv_choppy = $urandom_range(0, 1);
            end
            recv_run--;
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req <= 1'b0;
            end else if (recv_choppy && !calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_ulaw.size() == 0) begin
                    $display("%0t: unexpected result ulaw_byte %02h position %0d last %0b",
                             $time, out_ch.ulaw_byte, out_ch.block_position,
                             out_ch.block_last);
                    errors++;
                end else begin
                    want = expected_ulaw.pop_front();
                    if (out_ch.ulaw_byte !== want.ulaw) begin
                        $display("%0t: ulaw_byte expected %02h actual %02h",
                                 $time, want.ulaw, out_ch.ulaw_byte);
                        errors++;
                    end
                    if (out_ch.block_position !== want.pos) begin
                        $display("%0t: block_position expected %0d actual %0d",
                                 $time, want.pos, out_ch.block_position);
                        errors++;
                    end
                    if (out_ch.block_last !== want.last) begin
                        $display("%0t: block_last expected %0b actual %0b",
                                 $time, want.last, out_ch.block_last);
                        errors++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("interleaved_pcm_to_ulaw_deframer_core test failed");
                $finish;
            end
        end
    end

    initial begin
        int frames;
        frames = 0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.rx_byte = 8'h00;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[r]) begin
            repeat (plan[r].reps) push_byte(plan[r].act, plan[r].b, plan[r].chk, plan[r].ulaw);
        end
        push_byte(1'b0, 8'h00);
        wait_all_results();

        // A long frame while the result side holds off, so the input backs up.
        send_frame(300, 1'b1);
        while (items_sent < 660) begin
            send_frame(-1, 1'b0);
            frames++;
            if (frames == 10) begin
                wait_all_results();
            end
        end

        calm <= 1'b1;
        send_frame(120, 1'b0);
        wait_all_results();
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("interleaved_pcm_to_ulaw_deframer_core test passed");
        end else begin
            $display("interleaved_pcm_to_ulaw_deframer_core test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/ipud_pkg.sv
rtl/core/ipud_ifs.sv
rtl/core/ipud_parser.sv
rtl/core/ipud_encoder.sv
rtl/core/interleaved_pcm_to_ulaw_deframer_core.sv
sim/tb.sv
